// ===== hw/rtl/bsfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_pkg
// Shared types and constants of the balance state feedback controller.
// ----------------------------------------------------------------------------
package bsfc_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FLAT = 2'd1,
        MODE_BAL  = 2'd2
    } t_mode;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_ANGLE  = 3'd1,
        MUL_RATE   = 3'd2,
        MUL_WHEEL  = 3'd3,
        MUL_INTEG  = 3'd4,
        MUL_EULER  = 3'd5,
        MUL_MAG_LO = 3'd6,
        MUL_MAG_HI = 3'd7
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        logic     acc_gain;
        logic     integ_upd;
        logic     mag_load;
        logic     pacc_lo;
        logic     pacc_hi;
        logic     fin;
        logic     out_load;
        logic     out_bal;
        t_mode    out_mode;
    } t_dp_cmd;

    localparam int CfgIndexWidth = 3;

    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_ANGLE    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_RATE     = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_WHEEL    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_GAIN_INTEGRAL = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_INV_MOTOR     = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_PERIOD = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_CURRENT_LIMIT = 3'd6;

    localparam logic signed [31:0] RST_GAIN_ANGLE    = -32'sd293195;
    localparam logic signed [31:0] RST_GAIN_RATE     = -32'sd35009;
    localparam logic signed [31:0] RST_GAIN_WHEEL    = -32'sd695;
    localparam logic signed [31:0] RST_GAIN_INTEGRAL = 32'sd131;
    localparam logic [30:0]        RST_INV_MOTOR     = 31'd1622166;
    localparam logic [31:0]        RST_SAMPLE_PERIOD = 32'd4294967;
    localparam logic [30:0]        RST_CURRENT_LIMIT = 31'd983040;

endpackage
`default_nettype wire

// ===== hw/rtl/bsfc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_datapath
// Configuration registers, shared multiplier, accumulators and output payload.
// ----------------------------------------------------------------------------
module bsfc_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsfc_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data,
    input  wire logic [95:0]                       i_in_data,
    input  wire bsfc_pkg::t_dp_cmd                 i_cmd,
    output logic      [31:0]                       o_demand,
    output logic                                   o_enable,
    output logic      [1:0]                        o_mode
);
    import bsfc_pkg::*;

    logic signed [31:0] r_gain_angle, r_gain_rate, r_gain_wheel, r_gain_integral;
    logic        [30:0] r_inv, r_lim;
    logic        [31:0] r_sp;

    logic signed [31:0] r_a, r_r, r_w;
    logic signed [31:0] r_integ;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_sum;
    logic        [63:0] r_mag;
    logic               r_mneg, r_mzero;
    logic        [94:0] r_pacc;
    logic signed [63:0] r_v;
    logic        [31:0] r_out_demand;
    logic               r_out_enable;
    logic        [1:0]  r_out_mode;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] term_sh, neg_prod, incr;
    logic signed [34:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic        [63:0] pm1, pos_v;
    logic               ovf;
    logic signed [63:0] lim64, n_v;
    logic        [31:0] n_demand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_angle    <= RST_GAIN_ANGLE;
            r_gain_rate     <= RST_GAIN_RATE;
            r_gain_wheel    <= RST_GAIN_WHEEL;
            r_gain_integral <= RST_GAIN_INTEGRAL;
            r_inv           <= RST_INV_MOTOR;
            r_sp            <= RST_SAMPLE_PERIOD;
            r_lim           <= RST_CURRENT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN_ANGLE:    r_gain_angle    <= i_cfg_data;
                CFG_GAIN_RATE:     r_gain_rate     <= i_cfg_data;
                CFG_GAIN_WHEEL:    r_gain_wheel    <= i_cfg_data;
                CFG_GAIN_INTEGRAL: r_gain_integral <= i_cfg_data;
                CFG_INV_MOTOR:     r_inv           <= i_cfg_data[30:0];
                CFG_SAMPLE_PERIOD: r_sp            <= i_cfg_data;
                CFG_CURRENT_LIMIT: r_lim           <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ANGLE: begin
                op_a = {r_gain_angle[31], r_gain_angle};
                op_b = {r_a[31], r_a};
            end
            MUL_RATE: begin
                op_a = {r_gain_rate[31], r_gain_rate};
                op_b = {r_r[31], r_r};
            end
            MUL_WHEEL: begin
                op_a = {r_gain_wheel[31], r_gain_wheel};
                op_b = {r_w[31], r_w};
            end
            MUL_INTEG: begin
                op_a = {r_gain_integral[31], r_gain_integral};
                op_b = {r_integ[31], r_integ};
            end
            MUL_EULER: begin
                op_a = {r_w[31], r_w};
                op_b = {1'b0, r_sp};
            end
            MUL_MAG_LO: begin
                op_a = {1'b0, r_mag[31:0]};
                op_b = {2'b00, r_inv};
            end
            MUL_MAG_HI: begin
                op_a = {1'b0, r_mag[63:32]};
                op_b = {2'b00, r_inv};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // floored gain term, forward euler increment and saturated integral
    always_comb begin
        term_sh   = r_prod >>> FRACTION_BITS;
        neg_prod  = -r_prod;
        incr      = neg_prod >>> 32;
        integ_sum = {{3{r_integ[31]}}, r_integ} + incr[34:0];
        if (integ_sum > 35'sd2147483647)
            integ_sat = 32'sh7fffffff;
        else if (integ_sum < -35'sd2147483648)
            integ_sat = 32'sh80000000;
        else
            integ_sat = integ_sum[31:0];
    end

    // floor of the signed current product, from its magnitude
    always_comb begin
        ovf   = |r_pacc[94:63];
        pm1   = r_pacc[63:0] - 64'd1;
        pos_v = r_pacc[63:0] >> FRACTION_BITS;
        lim64 = {33'b0, r_lim};
        if (r_mzero || r_inv == '0)
            n_v = '0;
        else if (ovf)
            n_v = r_mneg ? -lim64 : lim64;
        else if (r_mneg)
            n_v = ~(pm1 >> FRACTION_BITS);
        else
            n_v = pos_v;
    end

    always_comb begin
        if (!i_cmd.out_bal)
            n_demand = '0;
        else if (r_v > lim64)
            n_demand = {1'b0, r_lim};
        else if (r_v < -lim64)
            n_demand = -{1'b0, r_lim};
        else
            n_demand = r_v[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ_upd) begin
            r_integ <= integ_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (i_cmd.load_in) begin
            r_a   <= i_in_data[31:0];
            r_r   <= i_in_data[63:32];
            r_w   <= i_in_data[95:64];
            r_sum <= '0;
        end
        if (i_cmd.acc_gain)
            r_sum <= r_sum + term_sh[63:0];
        if (i_cmd.mag_load) begin
            // torque demand is the negated sum
            r_mag   <= r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
            r_mneg  <= !r_sum[63] && (r_sum != '0);
            r_mzero <= (r_sum == '0);
        end
        if (i_cmd.pacc_lo)
            r_pacc <= {31'b0, r_prod[63:0]};
        if (i_cmd.pacc_hi)
            r_pacc <= r_pacc + {r_prod[62:0], 32'b0};
        if (i_cmd.fin)
            r_v <= n_v;
        if (i_cmd.out_load) begin
            r_out_demand <= n_demand;
            r_out_enable <= (i_cmd.out_mode != MODE_IDLE);
            r_out_mode   <= i_cmd.out_mode;
        end
    end

    assign o_demand = r_out_demand;
    assign o_enable = r_out_enable;
    assign o_mode   = r_out_mode;

endmodule
`default_nettype wire

// ===== hw/rtl/bsfc_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_controller
// Tick sequencer and operating mode machine; drives the datapath commands.
// ----------------------------------------------------------------------------
module bsfc_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_in_button,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output bsfc_pkg::t_dp_cmd      o_cmd
);
    import bsfc_pkg::*;

    typedef enum logic [3:0] {
        S_IN, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_P0, S_P1, S_P2, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_bal, n_bal;
    logic   r_out_valid, n_out_valid;
    logic   in_acc, out_free;

    assign in_acc   = (r_state == S_IN) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_bal       = r_bal;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    n_state = S_M0;
                    n_bal   = (r_mode == MODE_BAL);
                    case (r_mode)
                        MODE_FLAT: n_mode = i_in_button ? MODE_BAL : MODE_FLAT;
                        MODE_BAL:  n_mode = i_in_button ? MODE_FLAT : MODE_BAL;
                        default:   n_mode = i_in_button ? MODE_FLAT : MODE_IDLE;
                    endcase
                end
            end
            S_M0:  n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_M3;
            S_M3:  n_state = S_M4;
            S_M4:  n_state = S_M5;
            S_M5:  n_state = S_P0;
            S_P0:  n_state = S_P1;
            S_P1:  n_state = S_P2;
            S_P2:  n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state     = S_IN;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_mode      <= MODE_IDLE;
            r_bal       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_bal       <= n_bal;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_NONE;
        o_cmd.load_in  = in_acc;
        o_cmd.out_bal  = r_bal;
        o_cmd.out_mode = r_mode;
        case (r_state)
            S_M0: o_cmd.mul_sel = MUL_ANGLE;
            S_M1: begin
                o_cmd.mul_sel  = MUL_RATE;
                o_cmd.acc_gain = 1'b1;
            end
            S_M2: begin
                o_cmd.mul_sel  = MUL_WHEEL;
                o_cmd.acc_gain = 1'b1;
            end
            S_M3: begin
                // integral term uses the value from before this tick
                o_cmd.mul_sel  = MUL_INTEG;
                o_cmd.acc_gain = 1'b1;
            end
            S_M4: begin
                o_cmd.mul_sel  = MUL_EULER;
                o_cmd.acc_gain = 1'b1;
            end
            S_M5: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mag_load  = 1'b1;
            end
            S_P0: o_cmd.mul_sel = MUL_MAG_LO;
            S_P1: begin
                o_cmd.mul_sel = MUL_MAG_HI;
                o_cmd.pacc_lo = 1'b1;
            end
            S_P2:  o_cmd.pacc_hi  = 1'b1;
            S_FIN: o_cmd.fin      = 1'b1;
            S_OUT: o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IN);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/balance_state_feedback_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// balance_state_feedback_controller
// State feedback balance controller with integral action on wheel speed.
// ----------------------------------------------------------------------------
// One input beat is one control tick and gives one output beat. After input
// acceptance a tick steps through states S_M0 to S_M5, S_P0 to S_P2 and
// S_FIN, and its result is loaded into the output register in S_OUT; no new
// beat is accepted until then, and S_OUT waits while the output is full. The
// sequence is set by a single shared 33x33 multiplier that forms seven
// products in turn: four gain products, the euler increment of the wheel
// integral and two partial products of the current conversion.
// A new tick is accepted while the previous result still waits on the output.
// Configuration writes are always ready; write registers only between ticks,
// while no tick is in flight, so that a tick sees one consistent set.
// ----------------------------------------------------------------------------
module balance_state_feedback_controller #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [95:0]                        s_axis_tdata,  // body_angle, gyro_rate, wheel_speed
    input  wire logic [0:0]                         s_axis_tuser,  // button_event
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [31:0]                        m_axis_tdata,  // current_demand
    output logic      [2:0]                         m_axis_tuser,  // motor_enable, mode
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [bsfc_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);
    import bsfc_pkg::*;

    t_dp_cmd     cmd;
    logic [31:0] demand;
    logic        enable;
    logic [1:0]  mode;

    assign o_cfg_ready = 1'b1;

    bsfc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_button (s_axis_tuser[0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    bsfc_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_demand    (demand),
        .o_enable    (enable),
        .o_mode      (mode)
    );

    assign m_axis_tdata = demand;
    assign m_axis_tuser = {mode, enable};

endmodule
`default_nettype wire
